@@ sv/box_filter_3x3_defines.svh @@
// assertion macros used by the checker file
`ifndef BOX_FILTER_3X3_DEFINES_SVH
`define BOX_FILTER_3X3_DEFINES_SVH

// checked only outside reset
`define BF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BF3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/bf3_pkg.sv @@
// types and constants of the 3x3 box filter
`default_nettype none

package bf3_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned OUT_POS_W   = 10;
  localparam int unsigned MAX_HEIGHT  = 1024;
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
  localparam int unsigned GRID_RESET  = 1024;
  localparam int unsigned MIN_DIM     = 3;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

  // sum of nine samples and the reciprocal multiply for division by nine
  localparam int unsigned SUM_W      = SAMPLE_BITS + 4;
  localparam int unsigned DIV9_SHIFT = SUM_W + 3;
  localparam int unsigned DIV9_MUL   = ((2 ** DIV9_SHIFT) + 8) / 9;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic border;
    logic mean_ready;
    logic frame_end;
  } bf3_flags_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0]   col;
    logic [OUT_POS_W-1:0]   row;
    logic [SAMPLE_BITS-1:0] value;
    logic                   run_last;
    logic                   frame_last;
  } bf3_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    bf3_res_t   res0;
    bf3_res_t   res1;
  } bf3_push_t;

endpackage

`default_nettype wire

@@ sv/bf3_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module bf3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ sv/bf3_win.sv @@
// 3x3 window, nine-sample sum and divide-by-nine result stage
`default_nettype none

module bf3_win #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             ld_i,
  input  wire logic [bf3_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]     col_i,
  input  wire logic [bf3_pkg::ROW_W-1:0]        row_i,
  input  wire bf3_pkg::bf3_flags_t              flags_i,
  input  wire logic [bf3_pkg::SAMPLE_BITS-1:0]  top_i,
  input  wire logic [bf3_pkg::SAMPLE_BITS-1:0]  mid_i,
  input  wire logic                             room_i,
  output logic                                  free_o,
  output bf3_pkg::bf3_push_t                    push_o
);

  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned SB     = bf3_pkg::SAMPLE_BITS;
  localparam int unsigned SW     = bf3_pkg::SUM_W;
  localparam int unsigned PW     = bf3_pkg::OUT_POS_W;
  localparam int unsigned PROD_W = SW + SW;

  // [0..2] column c-2, [3..5] column c-1, rows r-2, r-1, r
  logic [SB-1:0] win_q [6];
  logic [SB-1:0] win_d [6];

  logic                v2_q, v2_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic [SB-1:0]       smp_q;
  logic [AW-1:0]       col_q;
  logic [bf3_pkg::ROW_W-1:0] row_q;
  bf3_pkg::bf3_flags_t flg_q;

  logic              adv;
  logic [SW-1:0]     recip;
  logic [PROD_W-1:0] prod;
  logic [SB-1:0]     quot;
  bf3_pkg::bf3_res_t mean_r, bord_r;

  assign sum_d = SW'(win_q[0]) + SW'(win_q[1]) + SW'(win_q[2])
               + SW'(win_q[3]) + SW'(win_q[4]) + SW'(win_q[5])
               + SW'(top_i) + SW'(mid_i) + SW'(sample_i);

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_d[i] = win_q[i];
    end
    if (ld_i) begin
      win_d[0] = win_q[3];
      win_d[1] = win_q[4];
      win_d[2] = win_q[5];
      win_d[3] = top_i;
      win_d[4] = mid_i;
      win_d[5] = sample_i;
    end
  end

  assign adv    = v2_q & room_i;
  assign free_o = ~v2_q | adv;

  always_comb begin
    v2_d = v2_q;
    if (ld_i) begin
      v2_d = 1'b1;
    end else if (adv) begin
      v2_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      v2_q <= v2_d;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      sum_q <= sum_d;
      smp_q <= sample_i;
      col_q <= col_i;
      row_q <= row_i;
      flg_q <= flags_i;
    end
  end

  // floor(sum / 9) by reciprocal multiply
  assign recip = SW'(bf3_pkg::DIV9_MUL);
  assign prod  = PROD_W'(sum_q) * PROD_W'(recip);
  assign quot  = prod[bf3_pkg::DIV9_SHIFT +: SB];

  always_comb begin
    mean_r.col        = PW'(32'(col_q) - 32'd1);
    mean_r.row        = PW'(32'(row_q) - 32'd1);
    mean_r.value      = quot;
    mean_r.run_last   = ~flg_q.border;
    mean_r.frame_last = 1'b0;

    bord_r.col        = PW'(32'(col_q));
    bord_r.row        = PW'(32'(row_q));
    bord_r.value      = smp_q;
    bord_r.run_last   = 1'b1;
    bord_r.frame_last = flg_q.frame_end;
  end

  always_comb begin
    push_o.cnt  = 2'd0;
    push_o.res0 = bord_r;
    push_o.res1 = bord_r;
    if (adv) begin
      if (flg_q.mean_ready) begin
        push_o.res0 = mean_r;
        push_o.cnt  = flg_q.border ? 2'd2 : 2'd1;
      end else if (flg_q.border) begin
        push_o.cnt  = 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/bf3_outq.sv @@
// result queue taking up to two words per cycle
`default_nettype none

module bf3_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bf3_pkg::bf3_push_t push_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output bf3_pkg::bf3_res_t       head_o
);

  localparam int unsigned QA = bf3_pkg::Q_AW;
  localparam int unsigned QC = bf3_pkg::Q_CW;

  bf3_pkg::bf3_res_t mem_q [bf3_pkg::Q_DEPTH];

  logic [QA-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [QC-1:0] cnt_q, cnt_d;
  logic          pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & out_ready_i;
  assign room_o      = (cnt_q <= QC'(bf3_pkg::Q_DEPTH - 2));
  assign head_o      = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q + QA'(push_i.cnt);
    rp_d  = pop ? rp_q + QA'(1) : rp_q;
    cnt_d = cnt_q + QC'(push_i.cnt) - QC'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wp_q + QA'(1)] <= push_i.res1;
    end
  end

endmodule

`default_nettype wire

@@ sv/box_filter_3x3.sv @@
// top level of the streaming 3x3 box filter
//
//   port group   dir   handshake                 payload
//   in           in    in_valid_i / in_ready_o   sample_i
//   out          out   out_valid_o / out_ready_i out_col_o out_row_o out_value_o
//                                                run_last_o frame_last_o
//   cfg          in    cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// one input word per cycle while in_ready_o is high; a word reads both line buffers
// in the cycle it is taken, is summed as it passes into the window stage and is
// divided into the result queue as the window stage advances; up to two
// results per word leave a four-entry queue one per cycle while out_ready_i is high
// in_ready_o drops when the queue cannot take two more words and both stages are full
// reset clears control, window and counters; line buffers are not cleared
`default_nettype none

module box_filter_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [bf3_pkg::SAMPLE_BITS-1:0]    sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [bf3_pkg::OUT_POS_W-1:0]           out_col_o,
  output logic [bf3_pkg::OUT_POS_W-1:0]           out_row_o,
  output logic [bf3_pkg::SAMPLE_BITS-1:0]         out_value_o,
  output logic                                    run_last_o,
  output logic                                    frame_last_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bf3_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bf3_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = bf3_pkg::ROW_W;
  localparam int unsigned SB = bf3_pkg::SAMPLE_BITS;
  localparam int unsigned RST_WIDTH =
    (MAX_WIDTH < bf3_pkg::GRID_RESET) ? MAX_WIDTH : bf3_pkg::GRID_RESET;

  logic [AW-1:0] col_q, col_d, wlast_q, wlast_d;
  logic [RW-1:0] row_q, row_d, hlast_q, hlast_d;

  logic          v1_q, v1_d;
  logic [SB-1:0] smp1_q;
  logic [AW-1:0] col1_q;
  logic [RW-1:0] row1_q;
  bf3_pkg::bf3_flags_t flg1_q, flg0;

  logic          accept, adv1, s2_free, q_room;
  logic [SB-1:0] mid_rd, top_rd;
  logic [31:0]   cfg_val, w_clamp, h_clamp;

  bf3_pkg::bf3_push_t push;
  bf3_pkg::bf3_res_t  head;

  assign cfg_ready_o = 1'b1;

  assign adv1       = v1_q & s2_free;
  assign in_ready_o = ~v1_q | adv1;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    flg0.border     = (col_q == '0) || (row_q == '0) ||
                      (col_q == wlast_q) || (row_q == hlast_q);
    flg0.mean_ready = (col_q >= AW'(2)) && (row_q >= RW'(2));
    flg0.frame_end  = (col_q == wlast_q) && (row_q == hlast_q);
  end

  // clamp of written dimensions
  assign cfg_val = 32'(cfg_data_i);

  always_comb begin
    w_clamp = cfg_val;
    if (cfg_val < bf3_pkg::MIN_DIM) begin
      w_clamp = bf3_pkg::MIN_DIM;
    end else if (cfg_val > MAX_WIDTH) begin
      w_clamp = MAX_WIDTH;
    end
    h_clamp = cfg_val;
    if (cfg_val < bf3_pkg::MIN_DIM) begin
      h_clamp = bf3_pkg::MIN_DIM;
    end else if (cfg_val > bf3_pkg::MAX_HEIGHT) begin
      h_clamp = bf3_pkg::MAX_HEIGHT;
    end
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bf3_pkg::CFG_GRID_WIDTH: begin
          wlast_d = AW'(w_clamp - 32'd1);
          col_d   = '0;
          row_d   = '0;
        end
        bf3_pkg::CFG_GRID_HEIGHT: begin
          hlast_d = RW'(h_clamp - 32'd1);
          col_d   = '0;
          row_d   = '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col_q == wlast_q) begin
        col_d = '0;
        row_d = (row_q == hlast_q) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_comb begin
    v1_d = v1_q;
    if (accept) begin
      v1_d = 1'b1;
    end else if (adv1) begin
      v1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      wlast_q <= AW'(RST_WIDTH - 1);
      hlast_q <= RW'(bf3_pkg::GRID_RESET - 1);
      v1_q    <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
      v1_q    <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp1_q <= sample_i;
      col1_q <= col_q;
      row1_q <= row_q;
      flg1_q <= flg0;
    end
  end

  // previous row
  bf3_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_WIDTH)
  ) u_line_above (
    .clk_i     (clk_i),
    .wr_en_i   (adv1),
    .wr_addr_i (col1_q),
    .wr_data_i (smp1_q),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (mid_rd)
  );

  // row before that
  bf3_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_WIDTH)
  ) u_line_two_above (
    .clk_i     (clk_i),
    .wr_en_i   (adv1),
    .wr_addr_i (col1_q),
    .wr_data_i (mid_rd),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (top_rd)
  );

  bf3_win #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_i     (adv1),
    .sample_i (smp1_q),
    .col_i    (col1_q),
    .row_i    (row1_q),
    .flags_i  (flg1_q),
    .top_i    (top_rd),
    .mid_i    (mid_rd),
    .room_i   (q_room),
    .free_o   (s2_free),
    .push_o   (push)
  );

  bf3_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (q_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign out_col_o    = head.col;
  assign out_row_o    = head.row;
  assign out_value_o  = head.value;
  assign run_last_o   = head.run_last;
  assign frame_last_o = head.frame_last;

endmodule

`default_nettype wire

@@ sv/bf3_checker.sv @@
// port checker of the box filter and its bind
`default_nettype none
`include "box_filter_3x3_defines.svh"

module bf3_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic [bf3_pkg::OUT_POS_W-1:0]      out_col_o,
  input wire logic [bf3_pkg::OUT_POS_W-1:0]      out_row_o,
  input wire logic [bf3_pkg::SAMPLE_BITS-1:0]    out_value_o,
  input wire logic                               run_last_o,
  input wire logic                               frame_last_o
);

  // nothing leaves while in reset
  `BF3_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result word during reset")

  `BF3_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_value_o) && $stable(out_col_o) && $stable(out_row_o) && $stable(run_last_o) && $stable(frame_last_o), "stalled result word changed")

  // a mean that opens a pair is followed at once by its border word one step down-right
  `BF3_ASSERT(a_pair_follows, out_valid_o && out_ready_i && !run_last_o |=> out_valid_o && run_last_o && (out_col_o == 10'($past(out_col_o) + 10'd1)) && (out_row_o == 10'($past(out_row_o) + 10'd1)), "second word of pair missing")

  `BF3_ASSERT(a_frame_end_run, out_valid_o && frame_last_o |-> run_last_o, "frame end without run end")

endmodule

bind box_filter_3x3 bf3_checker u_bf3_checker (.*);

`default_nettype wire
